// File: src/ddfm_pkg.sv
package ddfm_pkg;

	// Limb format: base 1e9 limbs held in 30 bits.
	localparam int LIMB_W = 30;
	localparam logic [LIMB_W-1:0] GIG = 30'd1000000000;

	// Widths of limb products and of the cross-product sum.
	localparam int PROD_W = 2 * LIMB_W;
	localparam int SUM_W = PROD_W + 1;

	// Quotient of a SUM_W-bit value by 1e9 fits in QUO_W bits.
	localparam int QUO_W = 32;

	// The quotient estimate multiplies the top QUO_W dividend bits by
	// floor(2^61 / 1e9); the estimate is low by at most one.
	localparam int EST_SHIFT = SUM_W - QUO_W;
	localparam int EST_W = 2 * QUO_W;
	localparam logic [QUO_W-1:0] RECIP = 32'd2305843009;

	// Divide by 1e9 in three stages: estimate, back-multiply, correction.
	localparam int DIV_STEPS = 3;

	// Carry-resolve sum width and the doubled base.
	localparam int FIX_W = QUO_W + 1;
	localparam logic [FIX_W-1:0] TWO_GIG = 33'd2000000000;

	// Stage numbering across the whole pipeline.
	localparam int STG_MUL = 0;
	localparam int STG_ADD = 1;
	localparam int STG_DIV = 2;
	localparam int STG_FIN = STG_DIV + DIV_STEPS;
	localparam int FIN_STAGES = 3;
	localparam int NSTAGE = STG_FIN + FIN_STAGES;

	typedef enum logic [1:0] {
		ST_EXACT    = 2'd0,
		ST_INEXACT  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// One operand pair as it arrives on the input channel.
	typedef struct packed {
		logic              a_negative;
		logic [LIMB_W-1:0] a_int;
		logic [LIMB_W-1:0] a_frac;
		logic              b_negative;
		logic [LIMB_W-1:0] b_int;
		logic [LIMB_W-1:0] b_frac;
	} operand_t;

	// Raw limb products.
	typedef struct packed {
		logic              neg;
		logic [PROD_W-1:0] ff;
		logic [PROD_W-1:0] hh;
		logic [PROD_W-1:0] p1;
		logic [PROD_W-1:0] p2;
	} mul_stage_t;

	// Products ready for division: cross sum and frac product.
	typedef struct packed {
		logic              neg;
		logic [PROD_W-1:0] hh;
		logic [SUM_W-1:0]  s;
		logic [PROD_W-1:0] ff;
	} add_stage_t;

	// Divider lane after the reciprocal multiply.
	typedef struct packed {
		logic [EST_W-1:0] est;
		logic [QUO_W-1:0] lo;
	} est_lane_t;

	// Divider lane after the back-multiply of the estimate.
	typedef struct packed {
		logic [QUO_W-1:0] q;
		logic [QUO_W-1:0] qg;
		logic [QUO_W-1:0] lo;
	} qmul_lane_t;

	// Final quotient and remainder of one lane.
	typedef struct packed {
		logic [LIMB_W-1:0] r;
		logic [QUO_W-1:0]  q;
	} lane_t;

	typedef struct packed {
		logic              neg;
		logic [PROD_W-1:0] hh;
		est_lane_t         sa;
		est_lane_t         fa;
	} est_stage_t;

	typedef struct packed {
		logic              neg;
		logic [PROD_W-1:0] hh;
		qmul_lane_t        sa;
		qmul_lane_t        fa;
	} qmul_stage_t;

	typedef struct packed {
		logic              neg;
		logic [PROD_W-1:0] hh;
		lane_t             sa;
		lane_t             fa;
	} div_stage_t;

	typedef struct packed {
		logic              neg;
		logic [LIMB_W-1:0] p_int;
		logic [LIMB_W-1:0] p_frac;
		status_t           status;
	} result_t;

	// Scaled reciprocal times the top dividend bits; keep the low bits for later.
	function automatic est_lane_t div_est(logic [SUM_W-1:0] x);
		est_lane_t l;
		l.est = EST_W'(x[SUM_W-1:EST_SHIFT]) * EST_W'(RECIP);
		l.lo = x[QUO_W-1:0];
		return l;
	endfunction

	// Estimate times 1e9; only the low bits matter since the remainder is small.
	function automatic qmul_lane_t div_mul(est_lane_t l);
		qmul_lane_t n;
		n.q = l.est[EST_W-1:QUO_W];
		n.qg = n.q * QUO_W'(GIG);
		n.lo = l.lo;
		return n;
	endfunction

	// The trial remainder is below 2e9, so one subtract corrects it.
	function automatic lane_t div_fix(qmul_lane_t l);
		lane_t n;
		logic [QUO_W-1:0] r;
		r = l.lo - l.qg;
		if (r >= QUO_W'(GIG)) begin
			n.r = LIMB_W'(r - QUO_W'(GIG));
			n.q = l.q + QUO_W'(1);
		end else begin
			n.r = LIMB_W'(r);
			n.q = l.q;
		end
		return n;
	endfunction

endpackage

// File: src/ddfm_in_if.sv
interface ddfm_in_if;
	import ddfm_pkg::*;

	logic              valid;
	logic              ready;
	logic              a_negative;
	logic [LIMB_W-1:0] a_int;
	logic [LIMB_W-1:0] a_frac;
	logic              b_negative;
	logic [LIMB_W-1:0] b_int;
	logic [LIMB_W-1:0] b_frac;

	modport source (
		output valid, a_negative, a_int, a_frac, b_negative, b_int, b_frac,
		input  ready
	);
	modport sink (
		input  valid, a_negative, a_int, a_frac, b_negative, b_int, b_frac,
		output ready
	);
endinterface

// File: src/ddfm_out_if.sv
interface ddfm_out_if;
	import ddfm_pkg::*;

	logic              valid;
	logic              ready;
	logic              p_negative;
	logic [LIMB_W-1:0] p_int;
	logic [LIMB_W-1:0] p_frac;
	logic [1:0]        status;

	modport source (
		output valid, p_negative, p_int, p_frac, status,
		input  ready
	);
	modport sink (
		input  valid, p_negative, p_int, p_frac, status,
		output ready
	);
endinterface

// File: src/ddfm_ctrl.sv
module ddfm_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      out_ready,
	output logic                      in_ready,
	output logic                      out_valid,
	output logic [ddfm_pkg::NSTAGE-1:0] en
);
	import ddfm_pkg::*;

	logic [NSTAGE-1:0] vld_q;
	logic [NSTAGE-1:0] vld_nxt;

	// A stage may load when any stage at or after it is empty or the last beat leaves.
	for (genvar k = 0; k < NSTAGE; k++) begin : g_en
		assign en[k] = out_ready | ~(&vld_q[NSTAGE-1:k]);
	end

	assign vld_nxt = {vld_q[NSTAGE-2:0], in_valid};

	// Valid bits move with the data, one stage per load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NSTAGE; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_nxt[k];
				end
			end
		end
	end

	assign in_ready = en[0];
	assign out_valid = vld_q[NSTAGE-1];

	// A waiting result is not dropped while the sink stalls.
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat lost during stall");

	// A bubble anywhere in the pipeline lets a new beat in.
	a_fill_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!(&vld_q) |-> in_ready)
		else $error("input stalled with a free stage");

	// An accepted beat always occupies the first stage next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted beat missing from first stage");

endmodule

// File: src/ddfm_mul.sv
module ddfm_mul (
	input  logic                 clk,
	input  logic [1:0]           en,
	input  ddfm_pkg::operand_t   opnd,
	output ddfm_pkg::add_stage_t add_out
);
	import ddfm_pkg::*;

	mul_stage_t mul_s1;
	add_stage_t add_s2;

	// Four limb products, one 30x30 multiplier each.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			mul_s1.neg <= opnd.a_negative ^ opnd.b_negative;
			mul_s1.ff <= PROD_W'(opnd.a_frac) * PROD_W'(opnd.b_frac);
			mul_s1.hh <= PROD_W'(opnd.a_int) * PROD_W'(opnd.b_int);
			mul_s1.p1 <= PROD_W'(opnd.a_int) * PROD_W'(opnd.b_frac);
			mul_s1.p2 <= PROD_W'(opnd.a_frac) * PROD_W'(opnd.b_int);
		end
	end

	// Sum of the two cross products.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			add_s2.neg <= mul_s1.neg;
			add_s2.hh <= mul_s1.hh;
			add_s2.ff <= mul_s1.ff;
			add_s2.s <= SUM_W'(mul_s1.p1) + SUM_W'(mul_s1.p2);
		end
	end

	assign add_out = add_s2;

endmodule

// File: src/ddfm_div.sv
module ddfm_div (
	input  logic                        clk,
	input  logic [ddfm_pkg::DIV_STEPS-1:0] en,
	input  ddfm_pkg::add_stage_t        add_in,
	output ddfm_pkg::div_stage_t        div_out
);
	import ddfm_pkg::*;

	est_stage_t  est_s1;
	qmul_stage_t qmul_s2;
	div_stage_t  div_s3;

	// Two lanes divide by 1e9 side by side: the cross sum and the frac product.
	// Quotient estimate from the reciprocal.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			est_s1.neg <= add_in.neg;
			est_s1.hh <= add_in.hh;
			est_s1.sa <= div_est(add_in.s);
			est_s1.fa <= div_est(SUM_W'(add_in.ff));
		end
	end

	// Estimate multiplied back by 1e9.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			qmul_s2.neg <= est_s1.neg;
			qmul_s2.hh <= est_s1.hh;
			qmul_s2.sa <= div_mul(est_s1.sa);
			qmul_s2.fa <= div_mul(est_s1.fa);
		end
	end

	// Remainder and a one-step correction of the quotient.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			div_s3.neg <= qmul_s2.neg;
			div_s3.hh <= qmul_s2.hh;
			div_s3.sa <= div_fix(qmul_s2.sa);
			div_s3.fa <= div_fix(qmul_s2.fa);
		end
	end

	assign div_out = div_s3;

endmodule

// File: src/ddfm_fin.sv
module ddfm_fin (
	input  logic                 clk,
	input  logic [2:0]           en,
	input  ddfm_pkg::div_stage_t div_in,
	output ddfm_pkg::result_t    res
);
	import ddfm_pkg::*;

	logic              neg_s1;
	logic [PROD_W-1:0] hh_s1;
	logic [QUO_W-1:0]  qs_s1;
	logic [FIX_W-1:0]  t_s1;
	logic              lost_s1;

	logic              neg_s2;
	logic [PROD_W-1:0] hh_s2;
	logic [QUO_W-1:0]  qs_s2;
	logic [1:0]        c_s2;
	logic [LIMB_W-1:0] frac_s2;
	logic              lost_s2;

	result_t           res_s3;

	logic [1:0]        c_nxt;
	logic [FIX_W-1:0]  r_nxt;
	logic [SUM_W-1:0]  pint_sum;

	// Fold the frac quotient into the cross-sum remainder.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_s1 <= div_in.neg;
			hh_s1 <= div_in.hh;
			qs_s1 <= div_in.sa.q;
			t_s1 <= FIX_W'(div_in.sa.r) + FIX_W'(div_in.fa.q);
			lost_s1 <= (div_in.fa.r != '0);
		end
	end

	// The folded value stays below 3e9, so at most two carries leave it.
	always_comb begin
		if (t_s1 >= TWO_GIG) begin
			c_nxt = 2'd2;
			r_nxt = t_s1 - TWO_GIG;
		end else if (t_s1 >= FIX_W'(GIG)) begin
			c_nxt = 2'd1;
			r_nxt = t_s1 - FIX_W'(GIG);
		end else begin
			c_nxt = 2'd0;
			r_nxt = t_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			neg_s2 <= neg_s1;
			hh_s2 <= hh_s1;
			qs_s2 <= qs_s1;
			c_s2 <= c_nxt;
			frac_s2 <= LIMB_W'(r_nxt);
			lost_s2 <= lost_s1;
		end
	end

	// Integer limb, overflow test and status; lost precision wins.
	assign pint_sum = SUM_W'(hh_s2) + SUM_W'(qs_s2) + SUM_W'(c_s2);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			res_s3.neg <= neg_s2;
			if (lost_s2) begin
				res_s3.status <= ST_INEXACT;
				res_s3.p_int <= '0;
				res_s3.p_frac <= '0;
			end else if (pint_sum >= SUM_W'(GIG)) begin
				res_s3.status <= ST_OVERFLOW;
				res_s3.p_int <= '0;
				res_s3.p_frac <= '0;
			end else begin
				res_s3.status <= ST_EXACT;
				res_s3.p_int <= pint_sum[LIMB_W-1:0];
				res_s3.p_frac <= frac_s2;
			end
		end
	end

	assign res = res_s3;

endmodule

// File: src/decimal_fixed_multiply.sv
// Channel   Direction  Beat contents
// op        in         a_negative, a_int, a_frac, b_negative, b_int, b_frac
// prod      out        p_negative, p_int, p_frac, status
//
// A beat passes the limb multipliers and cross-product add, the divide by
// 1e9 (reciprocal estimate, back-multiply, correction), then carry fold and
// status, each step registered. Reset clears only the valid bits.
// One operand pair is accepted every cycle unless every stage is full and the
// result stalls. A stalled result holds; earlier stages fill until all are full.
module decimal_fixed_multiply (
	input  logic       clk,
	input  logic       arst_n,
	ddfm_in_if.sink    op,
	ddfm_out_if.source prod
);
	import ddfm_pkg::*;

	logic [NSTAGE-1:0] en;
	operand_t          opnd;
	add_stage_t        add_o;
	div_stage_t        div_o;
	result_t           res;

	// Pipeline occupancy and per-stage load enables.
	ddfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (op.valid),
		.out_ready (prod.ready),
		.in_ready  (op.ready),
		.out_valid (prod.valid),
		.en        (en)
	);

	assign opnd.a_negative = op.a_negative;
	assign opnd.a_int = op.a_int;
	assign opnd.a_frac = op.a_frac;
	assign opnd.b_negative = op.b_negative;
	assign opnd.b_int = op.b_int;
	assign opnd.b_frac = op.b_frac;

	ddfm_mul u_mul (
		.clk     (clk),
		.en      (en[STG_ADD:STG_MUL]),
		.opnd    (opnd),
		.add_out (add_o)
	);

	ddfm_div u_div (
		.clk     (clk),
		.en      (en[STG_FIN-1:STG_DIV]),
		.add_in  (add_o),
		.div_out (div_o)
	);

	ddfm_fin u_fin (
		.clk    (clk),
		.en     (en[NSTAGE-1:STG_FIN]),
		.div_in (div_o),
		.res    (res)
	);

	assign prod.p_negative = res.neg;
	assign prod.p_int = res.p_int;
	assign prod.p_frac = res.p_frac;
	assign prod.status = res.status;

	// A failed product never carries digits.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		prod.valid && (prod.status == ST_INEXACT || prod.status == ST_OVERFLOW)
		|-> prod.p_int == '0 && prod.p_frac == '0)
		else $error("failed product has nonzero limbs");

	// Result limbs stay in base 1e9 range.
	a_limb_range: assert property (@(posedge clk) disable iff (!arst_n)
		prod.valid |-> prod.p_int < GIG && prod.p_frac < GIG)
		else $error("result limb out of range");

	// Status never takes the unused code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		prod.valid |-> prod.status == ST_EXACT || prod.status == ST_INEXACT
			|| prod.status == ST_OVERFLOW)
		else $error("undefined status code");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
	import ddfm_pkg::*;

	localparam int unsigned NINES = 999999999;
	localparam int unsigned HALF = 500000000;
	localparam int unsigned LIMB_MAX = (1 << LIMB_W) - 1;
	localparam int LONG_HOLD = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 100;

	// Keeps the products still owed by the block and checks them in order.
	class product_scoreboard;
		result_t owed_q[$];
		int mismatches;

		// Exact product of two base-1e9 fixed-point numbers, with the status rules.
		function result_t fixed_product(operand_t x);
			longint unsigned base, ai, af, bi, bf, ff, hh, mid, pint, pfrac;
			result_t r;
			base = GIG;
			ai = x.a_int;
			af = x.a_frac;
			bi = x.b_int;
			bf = x.b_frac;
			r.neg = x.a_negative ^ x.b_negative;
			r.p_int = '0;
			r.p_frac = '0;
			r.status = ST_EXACT;
			ff = af * bf;
			hh = ai * bi;
			// Digits left below 1e-9 win over any overflow.
			if (ff % base != 0) begin
				r.status = ST_INEXACT;
			end else begin
				mid = ai * bf + af * bi + ff / base;
				pint = hh + mid / base;
				pfrac = mid % base;
				if (hh >= base || pint >= base) begin
					r.status = ST_OVERFLOW;
				end else begin
					r.p_int = LIMB_W'(pint);
					r.p_frac = LIMB_W'(pfrac);
				end
			end
			return r;
		endfunction

		function void note_operands(operand_t x);
			owed_q.push_back(fixed_product(x));
		endfunction

		// Reports stop after the first hundred to keep the log readable.
		function void check_product(result_t got);
			result_t want;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: product beat with none owed: ", $time,
						"neg=%0d int=%0d frac=%0d status=%0d",
						got.neg, got.p_int, got.p_frac, got.status);
				return;
			end
			want = owed_q.pop_front();
			if (got.neg !== want.neg || got.p_int !== want.p_int ||
					got.p_frac !== want.p_frac || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: product mismatch: ", $time,
						"expected neg=%0d int=%0d frac=%0d status=%0d, ",
						want.neg, want.p_int, want.p_frac, want.status,
						"actual neg=%0d int=%0d frac=%0d status=%0d",
						got.neg, got.p_int, got.p_frac, got.status);
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit tx_steady;
	bit rx_steady;
	bit hold_req;
	product_scoreboard sb = new();

	ddfm_in_if op();
	ddfm_out_if prod();

	decimal_fixed_multiply dut (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.prod(prod)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(12 * 1000000);
		$display("tb_top failed");
		$finish;
	end

	// Mostly back to back, sometimes a few cycles, rarely a long pause; always back to back when steady.
	function automatic int pick_gap(bit steady);
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic int unsigned pow10(int unsigned m);
		int unsigned p;
		p = 1;
		repeat (m) p = p * 10;
		return p;
	endfunction

	function automatic operand_t pair(bit an, int unsigned ai, int unsigned af,
			bit bn, int unsigned bi, int unsigned bf);
		operand_t x;
		x.a_negative = an;
		x.a_int = LIMB_W'(ai);
		x.a_frac = LIMB_W'(af);
		x.b_negative = bn;
		x.b_int = LIMB_W'(bi);
		x.b_frac = LIMB_W'(bf);
		return x;
	endfunction

	// Most pairs are built so the fraction product is whole in 1e-9 units, and some
	// put the integer product near the overflow edge; the rest is raw 30-bit noise.
	function automatic operand_t random_operands();
		operand_t x;
		int unsigned m, q;
		x.a_negative = 1'($urandom_range(0, 1));
		x.b_negative = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 70) begin
			case ($urandom_range(0, 4))
				0: begin
					x.a_frac = '0;
					x.b_frac = LIMB_W'($urandom_range(0, NINES));
				end
				1: begin
					m = $urandom_range(0, 9);
					x.a_frac = LIMB_W'($urandom_range(0, pow10(9 - m) - 1) * pow10(m));
					x.b_frac = LIMB_W'($urandom_range(0, pow10(m) - 1) * pow10(9 - m));
				end
				2: begin
					x.a_frac = LIMB_W'($urandom_range(0, 1953124) * 512);
					x.b_frac = LIMB_W'($urandom_range(0, 511) * 1953125);
				end
				3: begin
					x.a_frac = LIMB_W'($urandom_range(0, 511) * 1953125);
					x.b_frac = LIMB_W'($urandom_range(0, 1953124) * 512);
				end
				default: begin
					x.a_frac = LIMB_W'($urandom_range(0, NINES));
					x.b_frac = LIMB_W'($urandom_range(0, NINES));
				end
			endcase
			case ($urandom_range(0, 3))
				0: begin
					x.a_int = LIMB_W'($urandom_range(0, 40000));
					x.b_int = LIMB_W'($urandom_range(0, 40000));
				end
				1: begin
					x.a_int = LIMB_W'($urandom_range(1, NINES));
					q = NINES / x.a_int;
					x.b_int = LIMB_W'(q + $urandom_range(0, 2) - 1);
				end
				2: begin
					x.a_int = '0;
					x.b_int = LIMB_W'($urandom_range(0, NINES));
				end
				default: begin
					x.a_int = LIMB_W'($urandom_range(0, NINES));
					x.b_int = LIMB_W'($urandom_range(0, NINES));
				end
			endcase
		end else begin
			x.a_int = LIMB_W'($urandom);
			x.a_frac = LIMB_W'($urandom);
			x.b_int = LIMB_W'($urandom);
			x.b_frac = LIMB_W'($urandom);
		end
		return x;
	endfunction

	// Offer one operand beat, wait for it to be taken, then maybe go idle.
	task automatic send_operands(input operand_t x);
		int gap;
		op.valid <= 1'b1;
		op.a_negative <= x.a_negative;
		op.a_int <= x.a_int;
		op.a_frac <= x.a_frac;
		op.b_negative <= x.b_negative;
		op.b_int <= x.b_int;
		op.b_frac <= x.b_frac;
		@(posedge clk);
		while (op.ready !== 1'b1) @(posedge clk);
		sb.note_operands(x);
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			op.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering until every owed product has come out.
	task automatic drain_products();
		op.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Result side: bursts of ready with random stalls, or one long hold when asked.
	initial begin
		int burst, gap;
		prod.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_req) begin
				prod.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				prod.ready <= 1'b1;
				burst = $urandom_range(1, 20);
				repeat (burst) @(posedge clk);
				gap = pick_gap(rx_steady);
				if (gap > 0) begin
					prod.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Check every product beat taken from the block.
	always @(posedge clk) begin : watch_products
		result_t got;
		if (arst_n === 1'b1 && prod.valid === 1'b1 && prod.ready === 1'b1) begin
			got.neg = prod.p_negative;
			got.p_int = prod.p_int;
			got.p_frac = prod.p_frac;
			got.status = status_t'(prod.status);
			sb.check_product(got);
		end
	end

	// Main sequence: directed corners, random traffic, back pressure, steady stream.
	initial begin
		operand_t corners[$];
		arst_n = 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_req = 1'b0;
		op.valid <= 1'b0;
		op.a_negative <= 1'b0;
		op.a_int <= '0;
		op.a_frac <= '0;
		op.b_negative <= 1'b0;
		op.b_int <= '0;
		op.b_frac <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero magnitudes keep the sign of the XOR, negative zero included.
		corners.push_back(pair(0, 0, 0, 0, 0, 0));
		corners.push_back(pair(1, 0, 0, 0, 0, 0));
		corners.push_back(pair(1, 0, 0, 1, 0, 0));
		corners.push_back(pair(0, 0, 0, 1, NINES, NINES));
		// Plain exact products.
		corners.push_back(pair(0, 1, 0, 0, 1, 0));
		corners.push_back(pair(1, 1, HALF, 0, 2, 250000000));
		corners.push_back(pair(0, 0, HALF, 1, 0, HALF));
		corners.push_back(pair(0, NINES, 0, 0, 1, 0));
		corners.push_back(pair(1, 123456789, HALF, 1, 8, 0));
		corners.push_back(pair(0, 0, 1, 0, NINES, 0));
		corners.push_back(pair(0, 0, 100000000, 0, 0, 10));
		corners.push_back(pair(0, 31622, 0, 0, 31622, 0));
		// Overflow, from the integer product and from a carry.
		corners.push_back(pair(0, 31623, 0, 1, 31623, 0));
		corners.push_back(pair(0, NINES, HALF, 0, 1, HALF));
		// Lost precision, also where the integer part would overflow.
		corners.push_back(pair(0, 0, NINES, 0, 0, NINES));
		corners.push_back(pair(1, NINES, 1, 0, NINES, 1));
		corners.push_back(pair(1, NINES, NINES, 1, NINES, NINES));
		// Limbs past 999999999 taken at their binary value.
		corners.push_back(pair(0, 0, LIMB_MAX, 0, 1, 0));
		corners.push_back(pair(1, LIMB_MAX, 0, 0, 1, 0));
		corners.push_back(pair(1, LIMB_MAX, LIMB_MAX, 1, LIMB_MAX, LIMB_MAX));
		foreach (corners[i]) send_operands(corners[i]);
		drain_products();

		repeat (700) send_operands(random_operands());

		// Hold the result side long enough for the pipe to fill and stall input.
		hold_req = 1'b1;
		tx_steady = 1'b1;
		repeat (300) send_operands(random_operands());
		tx_steady = 1'b0;
		drain_products();

		// Full rate on both sides.
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		repeat (300) send_operands(random_operands());
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		repeat (580) send_operands(random_operands());
		drain_products();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
